/* design/content_length_frame_parser_top_macros.svh */
// assertion macros for the content length frame parser
`ifndef CONTENT_LENGTH_FRAME_PARSER_TOP_MACROS_SVH
`define CONTENT_LENGTH_FRAME_PARSER_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CLFP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on the edge after its trigger
`define CLFP_ASSERT_NEXT(name, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

/* design/clfp_pkg.sv */
// shared types, constants and lookup functions of the content length frame parser
package clfp_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int COUNT_BITS = LENGTH_BITS + 1;
    localparam int MAX_DIGITS = 63;
    localparam int DIGIT_BITS = $clog2(MAX_DIGITS + 1);
    localparam int KEY_LEN = 15;
    localparam int KEY_BITS = $clog2(KEY_LEN + 1);
    localparam int PROD_BITS = LENGTH_BITS + 4;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] MAX_LEN_RESET = 16'hFFFF;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_KEY_FIRST = 8'h43;

    localparam logic [1:0] STATUS_BUSY = 2'd0;
    localparam logic [1:0] STATUS_ERROR = 2'd1;
    localparam logic [1:0] STATUS_OK = 2'd2;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_SKIP,
        PH_DIGITS,
        PH_CLOSED
    } phase_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  byte_count;
        logic [1:0]             end_prog;
        logic                   header_done;
        logic [LENGTH_BITS-1:0] header_bytes;
        logic [KEY_BITS-1:0]    key_prog;
        phase_t                 number_phase;
        logic [LENGTH_BITS-1:0] length_value;
        logic [DIGIT_BITS-1:0]  digit_count;
        logic                   value_too_big;
        logic                   nul_stuck;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [LENGTH_BITS-1:0] hdr_size;
        logic [LENGTH_BITS-1:0] body_size;
        logic [COUNT_BITS-1:0]  frame_size;
    } parse_result_t;

    function automatic logic [7:0] key_char(input logic [KEY_BITS-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            4'd14:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] end_char(input logic [1:0] idx);
        return idx[0] ? CHAR_LF : CHAR_CR;
    endfunction

endpackage

/* design/clfp_core.sv */
// per-byte parse state register and its next-state logic
module clfp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  start_new,
    output clfp_pkg::parse_state_t state_next
);

    clfp_pkg::parse_state_t state_reg;
    clfp_pkg::parse_state_t cur;
    logic                   digit;
    logic                   space;
    logic [clfp_pkg::DIGIT_BITS-1:0] cnt_inc;
    logic [clfp_pkg::PROD_BITS-1:0]  prod;

    always_comb
    begin
        if (start_new)
        begin
            cur = '0;
        end
        else
        begin
            cur = state_reg;
        end
        state_next = cur;
        digit = (data_byte >= clfp_pkg::CHAR_ZERO) && (data_byte <= clfp_pkg::CHAR_NINE);
        space = (data_byte == clfp_pkg::CHAR_SPACE) ||
                ((data_byte >= clfp_pkg::CHAR_TAB) && (data_byte <= clfp_pkg::CHAR_CR));
        cnt_inc = cur.digit_count + 1'b1;
        prod = {4'b0, cur.length_value} * clfp_pkg::PROD_BITS'(10)
             + {{(clfp_pkg::PROD_BITS-4){1'b0}}, data_byte[3:0]};

        if (cur.byte_count != clfp_pkg::COUNT_MAX)
        begin
            state_next.byte_count = cur.byte_count + 1'b1;
        end

        if (!cur.header_done && !cur.nul_stuck)
        begin
            if (data_byte == clfp_pkg::CHAR_NUL)
            begin
                state_next.nul_stuck = 1'b1;
            end
            else
            begin
                unique case (cur.number_phase)
                    clfp_pkg::PH_KEY:
                    begin
                        if ((cur.key_prog < clfp_pkg::KEY_BITS'(clfp_pkg::KEY_LEN)) &&
                            (data_byte == clfp_pkg::key_char(cur.key_prog)))
                        begin
                            state_next.key_prog = cur.key_prog + 1'b1;
                        end
                        else if (data_byte == clfp_pkg::CHAR_KEY_FIRST)
                        begin
                            state_next.key_prog = clfp_pkg::KEY_BITS'(1);
                        end
                        else
                        begin
                            state_next.key_prog = '0;
                        end
                        if (state_next.key_prog >= clfp_pkg::KEY_BITS'(clfp_pkg::KEY_LEN))
                        begin
                            state_next.number_phase = clfp_pkg::PH_SKIP;
                        end
                    end
                    clfp_pkg::PH_SKIP, clfp_pkg::PH_DIGITS:
                    begin
                        if (digit)
                        begin
                            if (cur.digit_count >= clfp_pkg::DIGIT_BITS'(clfp_pkg::MAX_DIGITS))
                            begin
                                state_next.number_phase = clfp_pkg::PH_CLOSED;
                            end
                            else
                            begin
                                state_next.digit_count = cnt_inc;
                                if (!cur.value_too_big)
                                begin
                                    if (prod > {4'b0, clfp_pkg::LEN_MAX})
                                    begin
                                        state_next.value_too_big = 1'b1;
                                    end
                                    else
                                    begin
                                        state_next.length_value =
                                            prod[clfp_pkg::LENGTH_BITS-1:0];
                                    end
                                end
                                if (cnt_inc >= clfp_pkg::DIGIT_BITS'(clfp_pkg::MAX_DIGITS))
                                begin
                                    state_next.number_phase = clfp_pkg::PH_CLOSED;
                                end
                                else
                                begin
                                    state_next.number_phase = clfp_pkg::PH_DIGITS;
                                end
                            end
                        end
                        else if ((cur.number_phase == clfp_pkg::PH_DIGITS) || !space)
                        begin
                            state_next.number_phase = clfp_pkg::PH_CLOSED;
                        end
                    end
                    clfp_pkg::PH_CLOSED:
                    begin
                    end
                endcase

                if (data_byte == clfp_pkg::end_char(cur.end_prog))
                begin
                    if (cur.end_prog == 2'd3)
                    begin
                        state_next.header_done = 1'b1;
                        state_next.end_prog = '0;
                        if (state_next.byte_count > {1'b0, clfp_pkg::LEN_MAX})
                        begin
                            state_next.header_bytes = clfp_pkg::LEN_MAX;
                        end
                        else
                        begin
                            state_next.header_bytes =
                                state_next.byte_count[clfp_pkg::LENGTH_BITS-1:0];
                        end
                    end
                    else
                    begin
                        state_next.end_prog = cur.end_prog + 1'b1;
                    end
                end
                else if (data_byte == clfp_pkg::CHAR_CR)
                begin
                    state_next.end_prog = 2'd1;
                end
                else
                begin
                    state_next.end_prog = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/clfp_status.sv */
// forms the status and length fields from the updated parse state
module clfp_status (
    input  clfp_pkg::parse_state_t       state,
    input  logic [clfp_pkg::LENGTH_BITS-1:0] max_len,
    output clfp_pkg::parse_result_t      result
);

    logic [clfp_pkg::COUNT_BITS-1:0] sum;

    always_comb
    begin
        sum = {1'b0, state.header_bytes} + {1'b0, state.length_value};
        result = '0;
        if (state.nul_stuck || !state.header_done)
        begin
            result.status = clfp_pkg::STATUS_BUSY;
        end
        else if ((state.digit_count == '0) || state.value_too_big ||
                 (state.length_value > max_len))
        begin
            result.status = clfp_pkg::STATUS_ERROR;
        end
        else if (sum > state.byte_count)
        begin
            result.status = clfp_pkg::STATUS_BUSY;
        end
        else
        begin
            result.status = clfp_pkg::STATUS_OK;
            result.hdr_size = state.header_bytes;
            result.body_size = state.length_value;
            result.frame_size = sum;
        end
    end

endmodule

/* design/content_length_frame_parser_top.sv */
// top level of the content length frame parser
// usage:
//   input stream: one received byte per beat on s_tdata, s_tuser set on the
//   first byte of a new buffer (clears all parse state, not the limit register)
//   output stream: one status beat per input beat, status on m_tuser and the
//   header, content and total lengths on m_tdata (zero unless status is ok)
//   cfg channel: cfg_data sets the largest accepted content length, always ready
// output: the result of a byte is registered and shown in the cycle after its beat is taken
// throughput: one byte per cycle unless the result register is stalled; the parse state
//   register updates in a single pass of matching and digit accumulation per beat
// stall: the result register holds while m_tready is low; s_tready stays high
//   as long as the result register is empty or being taken in the same cycle
// reset: rst_n clears the parse state and the output valid, and sets the
//   content length limit to 65535
module content_length_frame_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // header length, content length, total length, zero fill
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                             accept;
    logic [clfp_pkg::LENGTH_BITS-1:0] max_len_reg;
    logic                             m_valid_reg;
    clfp_pkg::parse_result_t          result_reg;
    clfp_pkg::parse_result_t          result_next;
    clfp_pkg::parse_state_t           state_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    clfp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .start_new  (s_tuser),
        .state_next (state_next)
    );

    clfp_status u_status (
        .state   (state_next),
        .max_len (max_len_reg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= clfp_pkg::MAX_LEN_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_len_reg <= cfg_data;
            end
            if (accept)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser = result_reg.status;
    assign m_tdata = {7'b0, result_reg.frame_size, result_reg.body_size,
                      result_reg.hdr_size};

endmodule

/* design/clfp_checker.sv */
// port-level checker for the content length frame parser and its bind
`include "content_length_frame_parser_top_macros.svh"

module clfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `CLFP_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `CLFP_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid,
        "no result after accepted beat")
    `CLFP_ASSERT(a_status_code, !m_tvalid || (m_tuser == clfp_pkg::STATUS_BUSY) ||
        (m_tuser == clfp_pkg::STATUS_ERROR) || (m_tuser == clfp_pkg::STATUS_OK),
        "unused status code")
    `CLFP_ASSERT(a_lengths_zero,
        !m_tvalid || (m_tuser == clfp_pkg::STATUS_OK) || (m_tdata == '0),
        "lengths set without ok")
    `CLFP_ASSERT(a_total_sum, !m_tvalid || (m_tuser != clfp_pkg::STATUS_OK) ||
        ({1'b0, m_tdata[15:0]} + {1'b0, m_tdata[31:16]} == m_tdata[48:32]),
        "total is not header plus content")

endmodule

bind content_length_frame_parser_top clfp_checker u_clfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* verif/content_length_frame_checker.sv */
`timescale 1ns / 100ps
// checker for the content length frame parser: predicts and compares status beats
module content_length_frame_checker
    import clfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // start_new
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // header length, content length, total length, zero fill
    input  logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          ok_seen,
    output int          error_seen
);

    localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "Content-Length:";
    localparam int CONTENT_LSB = LENGTH_BITS;
    localparam int TOTAL_LSB = 2 * LENGTH_BITS;
    localparam int FILL_LSB = TOTAL_LSB + COUNT_BITS;

    logic [COUNT_BITS-1:0]  rx_count;
    logic [1:0]             blank_prog;
    logic                   hdr_done;
    logic [LENGTH_BITS-1:0] hdr_len;
    int unsigned            key_pos;
    phase_t                 num_phase;
    logic [LENGTH_BITS-1:0] len_value;
    int unsigned            n_digits;
    logic                   too_big;
    logic                   nul_hold;
    logic [LENGTH_BITS-1:0] len_limit;
    parse_result_t          owed_results[$];

    function automatic logic [7:0] key_byte(input int unsigned pos);
        return KEY_TEXT[8*(KEY_LEN-1-pos) +: 8];
    endfunction

    function automatic void clear_parse();
        rx_count = '0;
        blank_prog = '0;
        hdr_done = 1'b0;
        hdr_len = '0;
        key_pos = 0;
        num_phase = PH_KEY;
        len_value = '0;
        n_digits = 0;
        too_big = 1'b0;
        nul_hold = 1'b0;
    endfunction

    function automatic void take_digit(input logic [7:0] b);
        logic [PROD_BITS-1:0] wide;
        if (n_digits >= MAX_DIGITS)
        begin
            num_phase = PH_CLOSED;
            return;
        end
        n_digits++;
        if (!too_big)
        begin
            wide = PROD_BITS'(len_value) * 10 + PROD_BITS'(b - CHAR_ZERO);
            if (wide > PROD_BITS'(LEN_MAX))
                too_big = 1'b1;
            else
                len_value = wide[LENGTH_BITS-1:0];
        end
        num_phase = (n_digits >= MAX_DIGITS) ? PH_CLOSED : PH_DIGITS;
    endfunction

    function automatic parse_result_t parse_byte(input logic [7:0] b, input logic first);
        parse_result_t         r;
        logic                  is_digit;
        logic                  is_ws;
        logic [7:0]            blank_char;
        logic [COUNT_BITS-1:0] frame_len;
        r = '0;
        if (first)
            clear_parse();
        if (rx_count != COUNT_MAX)
            rx_count++;

        if (!hdr_done && !nul_hold)
        begin
            if (b == CHAR_NUL)
                nul_hold = 1'b1;
            else
            begin
                is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
                is_ws = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
                case (num_phase)
                    PH_KEY:
                    begin
                        if (key_pos < KEY_LEN && b == key_byte(key_pos))
                            key_pos++;
                        else
                            key_pos = (b == CHAR_KEY_FIRST) ? 1 : 0;
                        if (key_pos >= KEY_LEN)
                            num_phase = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        if (is_digit)
                            take_digit(b);
                        else if (!is_ws)
                            num_phase = PH_CLOSED;
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                            take_digit(b);
                        else
                            num_phase = PH_CLOSED;
                    end
                    default:
                    begin
                    end
                endcase

                // blank line search: cr lf cr lf
                blank_char = blank_prog[0] ? CHAR_LF : CHAR_CR;
                if (b == blank_char)
                begin
                    if (blank_prog == 2'd3)
                    begin
                        hdr_done = 1'b1;
                        hdr_len = (rx_count > COUNT_BITS'(LEN_MAX)) ? LEN_MAX
                                                                    : rx_count[LENGTH_BITS-1:0];
                        blank_prog = '0;
                    end
                    else
                        blank_prog++;
                end
                else
                    blank_prog = (b == CHAR_CR) ? 2'd1 : 2'd0;
            end
        end

        frame_len = COUNT_BITS'(hdr_len) + COUNT_BITS'(len_value);
        if (nul_hold || !hdr_done)
            r.status = STATUS_BUSY;
        else if (n_digits == 0 || too_big || len_value > len_limit)
            r.status = STATUS_ERROR;
        else if (frame_len > rx_count)
            r.status = STATUS_BUSY;
        else
            r.status = STATUS_OK;

        if (r.status == STATUS_OK)
        begin
            r.hdr_size = hdr_len;
            r.body_size = len_value;
            r.frame_size = frame_len;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("checker: status beat %0d, %s: got %0d, want %0d",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n)
        begin
            clear_parse();
            len_limit = MAX_LEN_RESET;
            owed_results.delete();
            fail_count = 0;
            results_seen = 0;
            ok_seen = 0;
            error_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                    report("beat with nothing owed, status", 32'(m_tuser), 0);
                else
                begin
                    want = owed_results.pop_front();
                    if (m_tuser !== want.status)
                        report("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[CONTENT_LSB-1:0] !== want.hdr_size)
                        report("header length", 32'(m_tdata[CONTENT_LSB-1:0]),
                               32'(want.hdr_size));
                    if (m_tdata[TOTAL_LSB-1:CONTENT_LSB] !== want.body_size)
                        report("content length", 32'(m_tdata[TOTAL_LSB-1:CONTENT_LSB]),
                               32'(want.body_size));
                    if (m_tdata[FILL_LSB-1:TOTAL_LSB] !== want.frame_size)
                        report("total length", 32'(m_tdata[FILL_LSB-1:TOTAL_LSB]),
                               32'(want.frame_size));
                    if (m_tdata[55:FILL_LSB] !== '0)
                        report("fill bits", 32'(m_tdata[55:FILL_LSB]), 0);
                    if (want.status == STATUS_OK)
                        ok_seen++;
                    else if (want.status == STATUS_ERROR)
                        error_seen++;
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(parse_byte(s_tdata, s_tuser));
            if (cfg_valid && cfg_ready)
                len_limit = cfg_data;
            pending <= owed_results.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// testbench top for the content length frame parser: stimulus, idling, limit writes, verdict
module tb_top;
    import clfp_pkg::*;

    localparam int RUN_LIMIT = 40_000;
    localparam int MAX_SENT_CONTENT = 40;
    localparam int SEGMENT_BYTES = 64;
    localparam string CRLF = "\015\012";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int fail_count;
    int pending;
    int results_seen;
    int ok_seen;
    int error_seen;

    int unsigned            send_idle_pct = 0;
    int unsigned            recv_stall_pct = 0;
    int unsigned            cycle_count = 0;
    int                     bytes_sent = 0;
    int                     buffers_sent = 0;
    int                     limits_written = 0;
    logic [LENGTH_BITS-1:0] cur_limit = MAX_LEN_RESET;
    logic [7:0]             buf_q[$];

    content_length_frame_parser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    content_length_frame_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .ok_seen      (ok_seen),
        .error_seen   (error_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles, %0d beats still owed",
                     cycle_count, pending);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic push_byte(input logic [7:0] b, input logic first);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_limit = v;
        limits_written++;
    endtask

    task automatic send_buffer(input logic fresh);
        logic first;
        first = fresh;
        while (buf_q.size() != 0)
        begin
            push_byte(buf_q.pop_front(), first);
            first = 1'b0;
        end
        buffers_sent++;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            buf_q.push_back(s[i]);
    endfunction

    function automatic void add_random(input int n, input bit nul_ok);
        logic [7:0] c;
        repeat (n)
        begin
            c = 8'($urandom_range(255));
            if (!nul_ok && c == CHAR_NUL)
                c = "x";
            buf_q.push_back(c);
        end
    endfunction

    function automatic void add_letters(input int n);
        repeat (n)
            buf_q.push_back(8'("a" + $urandom_range(25)));
    endfunction

    function automatic void add_number(input int unsigned v, input int unsigned zeros);
        repeat (zeros)
            buf_q.push_back(CHAR_ZERO);
        add_text($sformatf("%0d", v));
    endfunction

    function automatic void add_header_line();
        case ($urandom_range(3))
            0:
            begin
                add_text("Host: ");
                add_letters($urandom_range(1, 6));
            end
            1: add_text("Content-Type: text");
            2: add_text("Conten: CContent-Lengt");
            default: add_text("content-length: 9");
        endcase
        add_text(CRLF);
    endfunction

    // whitespace between the key and the number, folded lines included
    function automatic void add_gap();
        case ($urandom_range(5))
            0: ;
            1: add_text(" ");
            2: add_text("\t");
            3: add_text("  \t");
            4: add_text({CRLF, " "});
            default: add_text("\013\014 ");
        endcase
    endfunction

    function automatic void build_good_frame();
        int unsigned declared;
        int unsigned sent;
        case ($urandom_range(9))
            0: declared = cur_limit;
            1: declared = cur_limit + 1;
            2: declared = $urandom_range(65535);
            default: declared = $urandom_range(16);
        endcase
        repeat ($urandom_range(2))
            add_header_line();
        add_text("Content-Length:");
        add_gap();
        add_number(declared, ($urandom_range(9) == 0) ? $urandom_range(4) : 0);
        if ($urandom_range(3) == 0)
            add_text("; q=1");
        add_text(CRLF);
        repeat ($urandom_range(1))
            add_header_line();
        add_text(CRLF);
        sent = (declared > MAX_SENT_CONTENT) ? $urandom_range(MAX_SENT_CONTENT) : declared;
        if (sent > 0 && $urandom_range(7) == 0)
            sent = $urandom_range(sent - 1);
        if ($urandom_range(4) == 0)
            sent += $urandom_range(3);
        add_random(sent, 1'b1);
    endfunction

    function automatic void build_broken_frame();
        case ($urandom_range(5))
            0: add_random($urandom_range(1, 24), 1'b1);
            1:
            begin
                repeat ($urandom_range(1, 3))
                    add_header_line();
                add_text(CRLF);
            end
            2:
            begin
                add_text({CRLF, CRLF, "Content-Length: 4", CRLF, CRLF});
                add_random(4, 1'b1);
            end
            3:
            begin
                add_text("Content-Length:");
                add_gap();
                if ($urandom_range(1) == 0)
                    add_text("abc");
                add_text({CRLF, CRLF});
            end
            4:
            begin
                add_text("Content-Length: 3");
                buf_q.push_back(CHAR_NUL);
                add_text({CRLF, CRLF, "abc"});
            end
            default:
            begin
                add_text("Content-Length: ");
                if ($urandom_range(1) == 0)
                    add_number($urandom_range(65536, 9_999_999), 0);
                else
                    repeat ($urandom_range(6, 70))
                        buf_q.push_back("9");
                add_text({CRLF, CRLF});
            end
        endcase
    endfunction

    task automatic send_text(input string s);
        add_text(s);
        send_buffer(1'b1);
    endtask

    task automatic run_directed();
        send_text({"Content-Length: 3", CRLF, CRLF, "abc"});
        send_text({"Content-Length:0", CRLF, CRLF});
        send_text({"A: b", CRLF, "Content-Length: 65535", CRLF, CRLF, "zz"});
        send_text({"Content-Length: 65536", CRLF, CRLF});
        send_text({"Content-Length: x", CRLF, CRLF});
        send_text({CRLF, CRLF, "Content-Length: 1", CRLF, CRLF, "q"});
        send_text({"CContent-Length: 1", CRLF, CRLF, "!"});
        // nul inside the header parks the parse
        add_text("Content-Length: 2");
        buf_q.push_back(CHAR_NUL);
        send_text({CRLF, CRLF, "ab"});
        // digits past the cap are dropped
        add_text("Content-Length: ");
        add_number(2, MAX_DIGITS - 1);
        send_text({"999", CRLF, CRLF, "hi"});
        add_text({"Content-Length: \t 4 ;x", CRLF, CRLF});
        buf_q.push_back(8'hFF);
        buf_q.push_back(CHAR_NUL);
        buf_q.push_back(8'h80);
        buf_q.push_back(8'h7F);
        send_buffer(1'b1);
        buf_q.push_back(8'hFF);
        send_buffer(1'b1);
        buf_q.push_back(CHAR_NUL);
        send_buffer(1'b1);
    endtask

    task automatic run_segment(input int unsigned idle, input int unsigned stall,
                               input logic [15:0] limit);
        int start;
        wait_drained();
        write_limit(limit);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        start = bytes_sent;
        while (bytes_sent - start < SEGMENT_BYTES)
        begin
            if ($urandom_range(9) < 7)
                build_good_frame();
            else
                build_broken_frame();
            send_buffer($urandom_range(11) != 0);
        end
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_limit(LEN_MAX);
        run_directed();

        run_segment(0, 0, LEN_MAX);
        run_segment(48, 0, '0);
        run_segment(0, 48, 16'd12);
        run_segment(12, 12, 16'd5);
        run_segment(0, 0, 16'($urandom_range(65535)));
        run_segment(48, 0, 16'd1);
        run_segment(0, 48, LEN_MAX);
        run_segment(12, 12, 16'($urandom_range(40)));

        wait_drained();
        repeat (4)
            @(posedge clk);

        $display("tb_top: %0d bytes in %0d buffers, %0d limit writes, four idle mixes",
                 bytes_sent, buffers_sent, limits_written);
        $display("tb_top: %0d status beats checked, %0d ok, %0d parse error, %0d mismatches",
                 results_seen, ok_seen, error_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
